/* src/ising_pkg.sv */
// ----------------------------------------------------------------------------
// ising_pkg
// Shared types and constants of the Ising Metropolis spin-update engine.
// ----------------------------------------------------------------------------
package ising_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_COUPLING_J = 2'd0;
  localparam logic [1:0] REG_FIELD_B    = 2'd1;
  localparam logic [1:0] REG_INV_TEMP   = 2'd2;

  // Item operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRIAL = 1'b1;

  // Site read slots: center and its four neighbors
  localparam logic [2:0] SLOT_CTR   = 3'd0;
  localparam logic [2:0] SLOT_UP    = 3'd1;
  localparam logic [2:0] SLOT_DOWN  = 3'd2;
  localparam logic [2:0] SLOT_LEFT  = 3'd3;
  localparam logic [2:0] SLOT_RIGHT = 3'd4;
  localparam int unsigned NUM_SLOTS = 5;

  // Index field width and reachable lattice extent
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned ADDR_W  = 2 * IDX_W;
  localparam int unsigned STORE_N = 1 << ADDR_W;
  localparam int unsigned SUM_W   = 12;

  // log2(e) in Q12
  localparam logic [12:0] LOG2E_Q12 = 13'd5909;

  // 2^(-k/16) in Q16, k = 0..16
  localparam logic [16:0] POW2_FRAC [17] = '{
    17'd65536, 17'd62757, 17'd60098, 17'd57550, 17'd55109, 17'd52773,
    17'd50535, 17'd48392, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  // Controller to datapath commands
  typedef struct packed {
    logic       capture;   // latch the input beat
    logic       rd_en;     // issue a spin read
    logic [2:0] rd_sel;    // which site slot to read
    logic       ev_de;     // energy change
    logic       ev_exp;    // exponent scaling
    logic       ev_log2;   // base-2 conversion
    logic       ev_mant;   // mantissa interpolation
    logic       ev_thr;    // threshold and decision
    logic       commit;    // write back, update sums, load result
  } ising_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;  // store initialization finished
    logic trial;     // held item is a flip trial
    logic oor;       // held site lies outside the lattice
    logic out_free;  // result register can take a new beat
  } ising_stat_t;

endpackage

/* src/ising_ctrl.sv */
// ----------------------------------------------------------------------------
// ising_ctrl
// Sequencer: reads the site and its neighbors, steps the acceptance
// evaluation for a flip trial and commits the result.
// ----------------------------------------------------------------------------
module ising_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ising_pkg::ising_stat_t stat_i,
  output ising_pkg::ising_cmd_t  cmd_o
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_RD0  = 13'b0000000000010,
    ST_RD1  = 13'b0000000000100,
    ST_RD2  = 13'b0000000001000,
    ST_RD3  = 13'b0000000010000,
    ST_RD4  = 13'b0000000100000,
    ST_CAP  = 13'b0000001000000,
    ST_E1   = 13'b0000010000000,
    ST_E2   = 13'b0000100000000,
    ST_E3   = 13'b0001000000000,
    ST_E4   = 13'b0010000000000,
    ST_E5   = 13'b0100000000000,
    ST_UPD  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   ready;

  assign ready      = (state_q == ST_IDLE) && stat_i.clr_done;
  assign in_ready_o = ready;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && ready) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RD0;
        end
      end
      ST_RD0: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ising_pkg::SLOT_CTR;
        state_d      = stat_i.oor ? ST_UPD : ST_RD1;
      end
      ST_RD1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ising_pkg::SLOT_UP;
        state_d      = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ising_pkg::SLOT_DOWN;
        state_d      = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ising_pkg::SLOT_LEFT;
        state_d      = ST_RD4;
      end
      ST_RD4: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = ising_pkg::SLOT_RIGHT;
        state_d      = ST_CAP;
      end
      ST_CAP: begin
        state_d = stat_i.trial ? ST_E1 : ST_UPD;
      end
      ST_E1: begin
        cmd_o.ev_de = 1'b1;
        state_d     = ST_E2;
      end
      ST_E2: begin
        cmd_o.ev_exp = 1'b1;
        state_d      = ST_E3;
      end
      ST_E3: begin
        cmd_o.ev_log2 = 1'b1;
        state_d       = ST_E4;
      end
      ST_E4: begin
        cmd_o.ev_mant = 1'b1;
        state_d       = ST_E5;
      end
      ST_E5: begin
        cmd_o.ev_thr = 1'b1;
        state_d      = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register is free
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/ising_dpath.sv */
// ----------------------------------------------------------------------------
// ising_dpath
// Spin store, configuration, running sums and the fixed-point acceptance
// evaluation of the Metropolis engine.
// ----------------------------------------------------------------------------
module ising_dpath #(
  parameter int unsigned SIDE = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_addr_i,
  input  logic [15:0]            cfg_wdata_i,
  // item fields
  input  logic                   op_i,
  input  logic [4:0]             row_i,
  input  logic [4:0]             col_i,
  input  logic                   spin_in_i,
  input  logic [15:0]            rand_req_i,
  // result handshake
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   accepted_o,
  output logic                   spin_out_o,
  output logic signed [11:0]     bond_sum_o,
  output logic signed [11:0]     magnetization_o,
  // control
  input  ising_pkg::ising_cmd_t  cmd_i,
  output ising_pkg::ising_stat_t stat_o
);

  localparam int unsigned AW        = ising_pkg::ADDR_W;
  localparam int unsigned SW        = ising_pkg::SUM_W;
  localparam logic [8:0]  SIDE_W    = 9'(SIDE);
  localparam int          PAIR_INIT = 2 * SIDE * (SIDE - 1);
  localparam int          SPIN_INIT = SIDE * SIDE;

  // Configuration registers
  logic signed [15:0] cfg_j_q, cfg_b_q;
  logic        [15:0] cfg_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_j_q <= 16'sd4096;
      cfg_b_q <= 16'sd0;
      cfg_t_q <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ising_pkg::REG_COUPLING_J: cfg_j_q <= cfg_wdata_i;
        ising_pkg::REG_FIELD_B:    cfg_b_q <= cfg_wdata_i;
        ising_pkg::REG_INV_TEMP:   cfg_t_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Held item
  logic        op_q, spin_in_q;
  logic [4:0]  row_q, col_q;
  logic [15:0] rand_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= op_i;
      row_q     <= row_i;
      col_q     <= col_i;
      spin_in_q <= spin_in_i;
      rand_q    <= rand_req_i;
    end
  end

  // Site geometry
  logic oor, has_up, has_down, has_left, has_right, edge_down, edge_right;

  assign oor        = !(9'(row_q) < SIDE_W) || !(9'(col_q) < SIDE_W);
  assign has_up     = (row_q != 5'd0);
  assign has_left   = (col_q != 5'd0);
  assign has_down   = (9'(row_q) + 9'd1) < SIDE_W;
  assign has_right  = (9'(col_q) + 9'd1) < SIDE_W;
  // neighbors beyond the reachable store are never written and stay up
  assign edge_down  = (row_q == 5'd31);
  assign edge_right = (col_q == 5'd31);

  // Store initialization sweep
  logic [AW-1:0] clr_cnt_q;
  logic          clr_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_done_q <= 1'b0;
    end else if (!clr_done_q) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
      if (clr_cnt_q == AW'(ising_pkg::STORE_N - 1)) begin
        clr_done_q <= 1'b1;
      end
    end
  end

  // Spin store read address
  logic [AW-1:0] raddr;

  always_comb begin
    case (cmd_i.rd_sel)
      ising_pkg::SLOT_UP:    raddr = {row_q - 5'd1, col_q};
      ising_pkg::SLOT_DOWN:  raddr = {row_q + 5'd1, col_q};
      ising_pkg::SLOT_LEFT:  raddr = {row_q, col_q - 5'd1};
      ising_pkg::SLOT_RIGHT: raddr = {row_q, col_q + 5'd1};
      default:               raddr = {row_q, col_q};
    endcase
  end

  // Spin store: one write and one registered read per cycle
  logic          store_q [ising_pkg::STORE_N];
  logic          rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic          new_spin, change;

  assign we    = !clr_done_q || (cmd_i.commit && change);
  assign waddr = clr_done_q ? {row_q, col_q} : clr_cnt_q;
  assign wdata = clr_done_q ? new_spin : 1'b1;

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[waddr] <= wdata;
    end
    rdata_q <= store_q[raddr];
  end

  // Capture read data in the cycle after its read
  logic       rd_vld_q;
  logic [2:0] rd_sel_q;
  logic       spin_q [ising_pkg::NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sel_q <= cmd_i.rd_sel;
    if (rd_vld_q) begin
      spin_q[rd_sel_q] <= rdata_q;
    end
  end

  // Neighbor sum, -4..4
  logic signed [3:0] v_up, v_down, v_left, v_right, nn;

  always_comb begin
    v_up    = !has_up    ? 4'sd0 : (spin_q[ising_pkg::SLOT_UP]   ? 4'sd1 : -4'sd1);
    v_left  = !has_left  ? 4'sd0 : (spin_q[ising_pkg::SLOT_LEFT] ? 4'sd1 : -4'sd1);
    v_down  = !has_down  ? 4'sd0 :
              ((edge_down || spin_q[ising_pkg::SLOT_DOWN]) ? 4'sd1 : -4'sd1);
    v_right = !has_right ? 4'sd0 :
              ((edge_right || spin_q[ising_pkg::SLOT_RIGHT]) ? 4'sd1 : -4'sd1);
    nn      = v_up + v_down + v_left + v_right;
  end

  // Stage 1: dE = 2*s*(J*nn + B), exact in Q12
  logic signed [21:0] e_c, de_c, de_q;

  assign e_c  = 22'(cfg_j_q) * 22'(nn) + 22'(cfg_b_q);
  assign de_c = spin_q[ising_pkg::SLOT_CTR] ? (e_c <<< 1) : -(e_c <<< 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_de) begin
      de_q <= de_c;
    end
  end

  // Stage 2: exponent x = round(dE * inv_temp) in Q12, clamp at 16.0
  logic [35:0] p_c;
  logic [23:0] x_c;
  logic [15:0] x_q;
  logic        sat_q;

  assign p_c = 36'(de_q[19:0]) * 36'(cfg_t_q);
  assign x_c = 24'((p_c + 36'd2048) >> 12);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_exp) begin
      x_q   <= x_c[15:0];
      sat_q <= |x_c[23:16];
    end
  end

  // Stage 3: base-2 exponent y = round(x * log2(e))
  logic [31:0] yp_c;
  logic [16:0] y_q;

  assign yp_c = 32'(x_q) * 32'(ising_pkg::LOG2E_Q12) + 32'd2048;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_log2) begin
      y_q <= yp_c[28:12];
    end
  end

  // Stage 4: mantissa 2^(-frac) by linear interpolation
  logic [3:0]  tbl_a;
  logic [7:0]  tbl_r;
  logic [16:0] lo, hi, m_c, m_q;
  logic [24:0] dm_c;
  logic [4:0]  n_q;

  assign tbl_a = y_q[11:8];
  assign tbl_r = y_q[7:0];
  assign lo    = ising_pkg::POW2_FRAC[5'(tbl_a)];
  assign hi    = ising_pkg::POW2_FRAC[5'(tbl_a) + 5'd1];
  assign dm_c  = 25'(lo - hi) * 25'(tbl_r) + 25'd128;
  assign m_c   = lo - 17'(dm_c >> 8);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_mant) begin
      m_q <= m_c;
      n_q <= y_q[16:12];
    end
  end

  // Stage 5: threshold and flip decision
  logic [39:0] tp_c;
  logic [16:0] thr_c;
  logic        de_le0, flip_c, flip_q;

  assign tp_c   = (40'(m_q) << 16) - 40'(m_q) + (40'd1 << (6'(n_q) + 6'd15));
  assign thr_c  = 17'(tp_c >> (6'(n_q) + 6'd16));
  assign de_le0 = de_q[21] || (de_q == '0);
  assign flip_c = de_le0 || (!sat_q && (17'(rand_q) < thr_c));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ev_thr) begin
      flip_q <= flip_c;
    end
  end

  // Commit: spin change and incremental sums
  logic                 old_spin;
  logic signed [SW-1:0] pair_q, spin_tot_q, pair_new, spin_new, nn2;

  assign old_spin = spin_q[ising_pkg::SLOT_CTR];
  assign new_spin = (op_q == ising_pkg::OP_TRIAL) ? !old_spin : spin_in_q;
  assign change   = !oor && (new_spin != old_spin) &&
                    ((op_q == ising_pkg::OP_LOAD) || flip_q);
  assign nn2      = SW'(nn) <<< 1;
  assign pair_new = pair_q + (new_spin ? nn2 : -nn2);
  assign spin_new = spin_tot_q + (new_spin ? SW'(2) : -SW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q     <= SW'(PAIR_INIT);
      spin_tot_q <= SW'(SPIN_INIT);
    end else if (cmd_i.commit && change) begin
      pair_q     <= pair_new;
      spin_tot_q <= spin_new;
    end
  end

  // Result register
  logic                 out_valid_q, acc_q, sout_q;
  logic signed [SW-1:0] bond_q, mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      acc_q  <= !oor && (op_q == ising_pkg::OP_TRIAL) && flip_q;
      sout_q <= oor ? 1'b0 : (change ? new_spin : old_spin);
      bond_q <= change ? pair_new : pair_q;
      mag_q  <= change ? spin_new : spin_tot_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign spin_out_o      = sout_q;
  assign bond_sum_o      = bond_q;
  assign magnetization_o = mag_q;

  // Status
  assign stat_o.clr_done = clr_done_q;
  assign stat_o.trial    = (op_q == ising_pkg::OP_TRIAL);
  assign stat_o.oor      = oor;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

endmodule

/* src/ising_metropolis_spin_update.sv */
// One item at a time: a load and a flip trial each pass through five reads of the
// spin store's single read port, and a trial also through the five-step acceptance
// evaluation; a site outside the lattice skips the neighbor reads and the evaluation.
// After reset the store is initialized to all spins up by a sweep over its 1024
// addresses; items are taken only once it ends, while configuration writes are
// taken at once.
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis spin-update engine for a 2D Ising lattice with open boundaries.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update #(
  parameter int unsigned SIDE = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // row[4:0], col[9:5], spin_in[10], rand_req[26:11]
  input  logic        s_axis_tuser,  // op[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // accepted[0], spin_out[1], bond_sum[13:2],
                                     // magnetization[25:14]
);

  ising_pkg::ising_cmd_t  cmd;
  ising_pkg::ising_stat_t stat;

  logic              accepted, spin_out;
  logic signed [11:0] bond_sum, magnetization;

  ising_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ising_dpath #(
    .SIDE (SIDE)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .op_i            (s_axis_tuser),
    .row_i           (s_axis_tdata[4:0]),
    .col_i           (s_axis_tdata[9:5]),
    .spin_in_i       (s_axis_tdata[10]),
    .rand_req_i      (s_axis_tdata[26:11]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .accepted_o      (accepted),
    .spin_out_o      (spin_out),
    .bond_sum_o      (bond_sum),
    .magnetization_o (magnetization),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

  // Pack the result beat
  assign m_axis_tdata = {6'd0, magnetization, bond_sum, spin_out, accepted};

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Ising Metropolis spin-update engine: random and
// directed load and flip-trial beats, scored against a behavioral lattice.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIDE = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic        op;
    logic [4:0]  row;
    logic [4:0]  col;
    logic        spin_in;
    logic [15:0] rand_req;
  } site_item_t;

  // fields from the highest bit down, so accepted lands in bit 0
  typedef struct packed {
    logic [11:0] magnetization;
    logic [11:0] bond_sum;
    logic        spin_out;
    logic        accepted;
  } site_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  ising_metropolis_spin_update #(.SIDE(SIDE)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Lattice shadow state
  logic        lat [SIDE*SIDE];
  int          pairs, spins;
  logic [15:0] j_q12, b_q12, beta_q12;

  site_item_t   pending_q [$];
  site_result_t result_q [$];
  int errors = 0, stall_cycles = 0, n_trials = 0, n_flips = 0;
  bit calm = 0;

  function automatic int spin_pm(int r, int c);
    return lat[r*SIDE+c] ? 1 : -1;
  endfunction

  function automatic int nn_sum(int r, int c);
    int s;
    s = 0;
    if (r > 0) s += spin_pm(r-1, c);
    if (r + 1 < SIDE) s += spin_pm(r+1, c);
    if (c > 0) s += spin_pm(r, c-1);
    if (c + 1 < SIDE) s += spin_pm(r, c+1);
    return s;
  endfunction

  function automatic longint flip_threshold(longint de);
    longint p, x, y, m, lo, hi, r;
    int n, a;
    longint tbl [17] = '{65536, 62757, 60098, 57550, 55109, 52773, 50535, 48392,
                         46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
    p = de * longint'(beta_q12);
    x = (p + 2048) >>> 12;
    if (x >= 65536) return 0;
    y = (x * 5909 + 2048) >>> 12;
    n = int'(y >>> 12);
    a = int'((y & 4095) >>> 8);
    r = y & 255;
    lo = tbl[a];
    hi = tbl[a+1];
    m = lo - (((lo - hi) * r + 128) >>> 8);
    return (m * 65535 + (longint'(1) << (15 + n))) >>> (16 + n);
  endfunction

  function automatic void write_site(int r, int c, logic up);
    int o, w;
    o = spin_pm(r, c);
    w = up ? 1 : -1;
    if (o != w) begin
      spins += w - o;
      pairs += (w - o) * nn_sum(r, c);
      lat[r*SIDE+c] = up;
    end
  endfunction

  function automatic site_result_t predict_site(site_item_t it);
    site_result_t res;
    int s, e, de, r, c;
    res = '0;
    r = int'(it.row);
    c = int'(it.col);
    if (r < SIDE && c < SIDE) begin
      if (it.op == ising_pkg::OP_LOAD) begin
        write_site(r, c, it.spin_in);
      end else begin
        n_trials++;
        s = spin_pm(r, c);
        e = int'($signed(j_q12)) * nn_sum(r, c) + int'($signed(b_q12));
        de = 2 * s * e;
        if (de <= 0 || longint'(it.rand_req) < flip_threshold(de)) begin
          res.accepted = 1'b1;
          n_flips++;
          write_site(r, c, s < 0);
        end
      end
      res.spin_out = lat[r*SIDE+c];
    end
    res.bond_sum = pairs[11:0];
    res.magnetization = spins[11:0];
    return res;
  endfunction

  // Driver: present the next queued beat, idle in random bursts
  int gap = 0;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      result_q.push_back(predict_site(pending_q.pop_front()));
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                   pending_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_q[0].op;
        s_axis_tdata <= {5'd0, pending_q[0].rand_req, pending_q[0].spin_in,
                         pending_q[0].col, pending_q[0].row};
        if (!calm && $urandom_range(0, 7) == 0) gap <= $urandom_range(1, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: score result beats, stall the sink in random bursts
  int sgap = 0;
  always @(posedge clk_i) begin
    site_result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[25:0];
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
          errors++;
        end
        if (got.spin_out !== want.spin_out) begin
          $error("spin_out: expected %0d actual %0d", want.spin_out, got.spin_out);
          errors++;
        end
        if (got.bond_sum !== want.bond_sum) begin
          $error("bond_sum: expected %0d actual %0d",
                 $signed(want.bond_sum), $signed(got.bond_sum));
          errors++;
        end
        if (got.magnetization !== want.magnetization) begin
          $error("magnetization: expected %0d actual %0d",
                 $signed(want.magnetization), $signed(got.magnetization));
          errors++;
        end
      end
    end
    if (sgap > 0) begin
      sgap <= sgap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) sgap <= $urandom_range(1, 12);
    end
  end

  // Watchdog: end the run after a long stretch with no beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      ising_pkg::REG_COUPLING_J: j_q12 = val;
      ising_pkg::REG_FIELD_B:    b_q12 = val;
      default:                   beta_q12 = val;
    endcase
  endtask

  // Hold until every queued beat has been scored, then settle
  task automatic drain();
    wait (pending_q.size() == 0 && result_q.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic site_item_t mk(logic op, int r, int c, logic s, int rnd);
    site_item_t it;
    it.op = op;
    it.row = 5'(r);
    it.col = 5'(c);
    it.spin_in = s;
    it.rand_req = 16'(rnd);
    return it;
  endfunction

  // Random phase: mostly trials, the rest loads, at in-range sites with random content
  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      pending_q.push_back(mk($urandom_range(0, 3) != 0, $urandom_range(0, 31),
                             $urandom_range(0, 31), 1'($urandom_range(0, 1)),
                             $urandom_range(0, 65535)));
    end
    drain();
  endtask

  initial begin
    foreach (lat[i]) lat[i] = 1'b1;
    pairs = 2 * SIDE * (SIDE - 1);
    spins = SIDE * SIDE;
    j_q12 = 16'd4096;
    b_q12 = 16'd0;
    beta_q12 = 16'd4096;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corners, interior sites, no-change load, trials at both rand extremes
    pending_q.push_back(mk(ising_pkg::OP_LOAD, 0, 0, 1'b1, 0));
    pending_q.push_back(mk(ising_pkg::OP_LOAD, 0, 0, 1'b0, 65535));
    pending_q.push_back(mk(ising_pkg::OP_LOAD, 31, 31, 1'b0, 0));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 0, 31, 1'b0, 0));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 31, 0, 1'b1, 65535));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 15, 16, 1'b0, 0));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 0, 0, 1'b0, 65535));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 31, 31, 1'b0, 12345));
    pending_q.push_back(mk(ising_pkg::OP_LOAD, 10, 21, 1'b0, 43690));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 10, 21, 1'b1, 21845));
    drain();

    // Infinite temperature, then extreme couplings and fields
    cfg_write(ising_pkg::REG_INV_TEMP, 16'd0);
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 5, 5, 1'b0, 65535));
    pending_q.push_back(mk(ising_pkg::OP_TRIAL, 6, 6, 1'b0, 65534));
    drain();
    cfg_write(ising_pkg::REG_COUPLING_J, 16'h7FFF);
    cfg_write(ising_pkg::REG_FIELD_B, 16'h8000);
    cfg_write(ising_pkg::REG_INV_TEMP, 16'hFFFF);
    random_phase(100);
    cfg_write(ising_pkg::REG_COUPLING_J, 16'h8000);
    cfg_write(ising_pkg::REG_FIELD_B, 16'h7FFF);
    cfg_write(ising_pkg::REG_INV_TEMP, 16'd1);
    random_phase(100);
    cfg_write(ising_pkg::REG_COUPLING_J, 16'd1024);
    cfg_write(ising_pkg::REG_FIELD_B, 16'hFF00);
    cfg_write(ising_pkg::REG_INV_TEMP, 16'd2048);
    random_phase(150);
    cfg_write(ising_pkg::REG_COUPLING_J, 16'd4096);
    cfg_write(ising_pkg::REG_FIELD_B, 16'd0);
    cfg_write(ising_pkg::REG_INV_TEMP, 16'd300);
    random_phase(150);
    calm = 1;
    cfg_write(ising_pkg::REG_INV_TEMP, 16'd4096);
    random_phase(150);
    repeat (50) @(posedge clk_i);

    $display("ran %0d trials (%0d flips) plus loads over five coupling/field/temp settings",
             n_trials, n_flips);
    if (errors == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
